>>> design/model_transform_matrix_top_defines.svh
// Assertion macros used by the checker file.
`ifndef MODEL_TRANSFORM_MATRIX_TOP_DEFINES_SVH
`define MODEL_TRANSFORM_MATRIX_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/mtm_pkg.sv
package mtm_pkg;

   localparam int CORDIC_W   = 34;
   localparam int ATAN_STEPS = 24;
   localparam int PROD_W     = 66;

   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] PI_Q30          = 34'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [31:0]         ONE_Q16         = 32'sh0001_0000;
   localparam logic [1:0]                 LAST_ROW        = 2'd3;

   typedef struct packed {
      logic signed [31:0] loc_x;
      logic signed [31:0] loc_y;
      logic signed [31:0] loc_z;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem_0;
      logic signed [31:0] elem_1;
      logic signed [31:0] elem_2;
      logic signed [31:0] elem_3;
      logic               last_row;
   } rsp_type;

   // Payload that rides alongside the trig and matrix stages.
   typedef struct packed {
      logic signed [31:0] loc_x;
      logic signed [31:0] loc_y;
      logic signed [31:0] loc_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } side_type;

   typedef struct packed {
      logic signed [31:0] sin_yaw;
      logic signed [31:0] cos_yaw;
      logic signed [31:0] sin_pitch;
      logic signed [31:0] cos_pitch;
      logic signed [31:0] sin_roll;
      logic signed [31:0] cos_roll;
   } trig_type;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         0:  v = 34'sd843314856;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043836;
         3:  v = 34'sd133525158;
         4:  v = 34'sd67021686;
         5:  v = 34'sd33543515;
         6:  v = 34'sd16775850;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194282;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q.30 product, round half up, floor shift.
   function automatic logic signed [CORDIC_W-1:0] mulq(
      input logic signed [CORDIC_W-1:0] a,
      input logic signed [CORDIC_W-1:0] b
   );
      logic signed [2*CORDIC_W-1:0] p;
      p = (2*CORDIC_W)'(a) * (2*CORDIC_W)'(b);
      p = p + (2*CORDIC_W)'(64'sd536870912);
      p = p >>> 30;
      return p[CORDIC_W-1:0];
   endfunction

endpackage

>>> design/mtm_cordic.sv
module mtm_cordic #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  mtm_pkg::req_type  in_data,
   output logic              out_valid,
   output mtm_pkg::trig_type out_trig,
   output mtm_pkg::side_type out_side
);

   localparam int W = mtm_pkg::CORDIC_W;
   localparam int NSTEP = (TRIG_ITERATIONS > mtm_pkg::ATAN_STEPS) ?
                          mtm_pkg::ATAN_STEPS : TRIG_ITERATIONS;

   logic signed [W-1:0] x_ff   [0:NSTEP][0:2];
   logic signed [W-1:0] y_ff   [0:NSTEP][0:2];
   logic signed [W-1:0] z_ff   [0:NSTEP][0:2];
   logic                neg_ff [0:NSTEP][0:2];
   logic                valid_ff [0:NSTEP];
   mtm_pkg::side_type   side_ff  [0:NSTEP];

   logic signed [15:0]  ang_in [0:2];
   logic signed [31:0]  sin_ff [0:2];
   logic signed [31:0]  cos_ff [0:2];
   logic                out_valid_ff;
   mtm_pkg::side_type   out_side_ff;

   assign ang_in[0] = in_data.yaw_angle;
   assign ang_in[1] = in_data.pitch_angle;
   assign ang_in[2] = in_data.roll_angle;

   // Range reduction into plus or minus pi/2.
   always_ff @(posedge clock) begin
      logic signed [W-1:0] zi;
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            zi = {{(W-33){ang_in[l][15]}}, ang_in[l], 17'd0};
            x_ff[0][l] <= mtm_pkg::CORDIC_GAIN_Q30;
            y_ff[0][l] <= '0;
            if (zi > mtm_pkg::HALF_PI_Q30) begin
               z_ff[0][l]   <= zi - mtm_pkg::PI_Q30;
               neg_ff[0][l] <= 1'b1;
            end else if (zi < -mtm_pkg::HALF_PI_Q30) begin
               z_ff[0][l]   <= zi + mtm_pkg::PI_Q30;
               neg_ff[0][l] <= 1'b1;
            end else begin
               z_ff[0][l]   <= zi;
               neg_ff[0][l] <= 1'b0;
            end
         end
         side_ff[0] <= '{loc_x: in_data.loc_x, loc_y: in_data.loc_y,
                         loc_z: in_data.loc_z, scale_x: in_data.scale_x,
                         scale_y: in_data.scale_y, scale_z: in_data.scale_z};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               if (z_ff[k][l] >= 0) begin
                  x_ff[k+1][l] <= x_ff[k][l] - (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] + (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] - mtm_pkg::atan_q30(k);
               end else begin
                  x_ff[k+1][l] <= x_ff[k][l] + (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] - (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] + mtm_pkg::atan_q30(k);
               end
               neg_ff[k+1][l] <= neg_ff[k][l];
            end
            side_ff[k+1] <= side_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   // Undo the half-turn fold.
   always_ff @(posedge clock) begin
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            xs = neg_ff[NSTEP][l] ? -x_ff[NSTEP][l] : x_ff[NSTEP][l];
            ys = neg_ff[NSTEP][l] ? -y_ff[NSTEP][l] : y_ff[NSTEP][l];
            cos_ff[l] <= xs[31:0];
            sin_ff[l] <= ys[31:0];
         end
         out_side_ff <= side_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[NSTEP];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_trig  = '{sin_yaw: sin_ff[0], cos_yaw: cos_ff[0],
                        sin_pitch: sin_ff[1], cos_pitch: cos_ff[1],
                        sin_roll: sin_ff[2], cos_roll: cos_ff[2]};

endmodule

>>> design/mtm_rot.sv
module mtm_rot (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  mtm_pkg::trig_type                     in_trig,
   input  mtm_pkg::side_type                     in_side,
   output logic                                  out_valid,
   output logic signed [mtm_pkg::CORDIC_W-1:0]   out_rot [0:2][0:2],
   output mtm_pkg::side_type                     out_side
);

   localparam int W = mtm_pkg::CORDIC_W;

   logic signed [W-1:0] sy, cy, sp, cp, sr, cr;

   // First products.
   logic signed [W-1:0] t_ff, u_ff, crcy_ff, srcy_ff, cpsy_ff, srcp_ff;
   logic signed [W-1:0] crcp_ff, crsy_ff, srsy_ff, cpcy_ff, sp1_ff, sy1_ff, cy1_ff;
   // Second products.
   logic signed [W-1:0] tsy_ff, usy_ff, tcy_ff, ucy_ff;
   logic signed [W-1:0] crcy2_ff, srcy2_ff, cpsy2_ff, srcp2_ff;
   logic signed [W-1:0] crcp2_ff, crsy2_ff, srsy2_ff, cpcy2_ff, sp2_ff;
   logic signed [W-1:0] rot_ff [0:2][0:2];

   logic              v1_ff, v2_ff, v3_ff;
   mtm_pkg::side_type s1_ff, s2_ff, s3_ff;

   assign sy = W'(in_trig.sin_yaw);
   assign cy = W'(in_trig.cos_yaw);
   assign sp = W'(in_trig.sin_pitch);
   assign cp = W'(in_trig.cos_pitch);
   assign sr = W'(in_trig.sin_roll);
   assign cr = W'(in_trig.cos_roll);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= mtm_pkg::mulq(sr, sp);
         u_ff    <= mtm_pkg::mulq(cr, sp);
         crcy_ff <= mtm_pkg::mulq(cr, cy);
         srcy_ff <= mtm_pkg::mulq(sr, cy);
         cpsy_ff <= mtm_pkg::mulq(cp, sy);
         srcp_ff <= mtm_pkg::mulq(sr, cp);
         crcp_ff <= mtm_pkg::mulq(cr, cp);
         crsy_ff <= mtm_pkg::mulq(cr, sy);
         srsy_ff <= mtm_pkg::mulq(sr, sy);
         cpcy_ff <= mtm_pkg::mulq(cp, cy);
         sp1_ff  <= sp;
         sy1_ff  <= sy;
         cy1_ff  <= cy;
         s1_ff   <= in_side;

         tsy_ff   <= mtm_pkg::mulq(t_ff, sy1_ff);
         usy_ff   <= mtm_pkg::mulq(u_ff, sy1_ff);
         tcy_ff   <= mtm_pkg::mulq(t_ff, cy1_ff);
         ucy_ff   <= mtm_pkg::mulq(u_ff, cy1_ff);
         crcy2_ff <= crcy_ff;
         srcy2_ff <= srcy_ff;
         cpsy2_ff <= cpsy_ff;
         srcp2_ff <= srcp_ff;
         crcp2_ff <= crcp_ff;
         crsy2_ff <= crsy_ff;
         srsy2_ff <= srsy_ff;
         cpcy2_ff <= cpcy_ff;
         sp2_ff   <= sp1_ff;
         s2_ff    <= s1_ff;

         rot_ff[0][0] <= crcy2_ff - tsy_ff;
         rot_ff[0][1] <= srcy2_ff + usy_ff;
         rot_ff[0][2] <= -cpsy2_ff;
         rot_ff[1][0] <= -srcp2_ff;
         rot_ff[1][1] <= crcp2_ff;
         rot_ff[1][2] <= sp2_ff;
         rot_ff[2][0] <= crsy2_ff + tcy_ff;
         rot_ff[2][1] <= srsy2_ff - ucy_ff;
         rot_ff[2][2] <= cpcy2_ff;
         s3_ff        <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_rot   = rot_ff;
   assign out_side  = s3_ff;

endmodule

>>> design/mtm_scale.sv
module mtm_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [mtm_pkg::CORDIC_W-1:0] in_rot [0:2][0:2],
   input  mtm_pkg::side_type                   in_side,
   output logic                                out_valid,
   output logic signed [31:0]                  out_elem [0:2][0:2],
   output mtm_pkg::side_type                   out_side
);

   localparam int PW = mtm_pkg::PROD_W;

   logic signed [31:0]    sc [0:2];
   logic signed [PW-1:0]  prod_ff [0:2][0:2];
   logic signed [31:0]    elem_ff [0:2][0:2];
   logic                  v1_ff, v2_ff;
   mtm_pkg::side_type     s1_ff, s2_ff;

   assign sc[0] = in_side.scale_x;
   assign sc[1] = in_side.scale_y;
   assign sc[2] = in_side.scale_z;

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] r;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= PW'(in_rot[i][j]) * PW'(sc[j]);
            end
         end
         s1_ff <= in_side;

         // Round half up, then clamp to 32 bits.
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               r = (prod_ff[i][j] + PW'(64'sd536870912)) >>> 30;
               if (r > PW'(64'sd2147483647)) begin
                  elem_ff[i][j] <= 32'sh7FFF_FFFF;
               end else if (r < -PW'(64'sd2147483648)) begin
                  elem_ff[i][j] <= 32'sh8000_0000;
               end else begin
                  elem_ff[i][j] <= r[31:0];
               end
            end
         end
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_elem  = elem_ff;
   assign out_side  = s2_ff;

endmodule

>>> design/mtm_rows.sv
module mtm_rows (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] in_elem [0:2][0:2],
   input  mtm_pkg::side_type  in_side,
   output logic               in_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mtm_pkg::rsp_type   rsp_data
);

   logic signed [31:0] elem_ff [0:2][0:2];
   logic signed [31:0] loc_ff  [0:2];
   logic               valid_ff;
   logic [1:0]         row_ff;
   logic               row_done;

   assign row_done = valid_ff && !rsp_stall;
   assign in_take  = !valid_ff || (row_done && row_ff == mtm_pkg::LAST_ROW);

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         elem_ff   <= in_elem;
         loc_ff[0] <= in_side.loc_x;
         loc_ff[1] <= in_side.loc_y;
         loc_ff[2] <= in_side.loc_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else if (in_take) begin
         valid_ff <= in_valid;
         row_ff   <= '0;
      end else if (row_done) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_data.row_index = row_ff;
      rsp_data.last_row  = (row_ff == mtm_pkg::LAST_ROW);
      case (row_ff)
         2'd0, 2'd1, 2'd2: begin
            rsp_data.elem_0 = elem_ff[row_ff][0];
            rsp_data.elem_1 = elem_ff[row_ff][1];
            rsp_data.elem_2 = elem_ff[row_ff][2];
            rsp_data.elem_3 = '0;
         end
         default: begin
            rsp_data.elem_0 = loc_ff[0];
            rsp_data.elem_1 = loc_ff[1];
            rsp_data.elem_2 = loc_ff[2];
            rsp_data.elem_3 = mtm_pkg::ONE_Q16;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

>>> design/model_transform_matrix_top.sv
// Scale-rotate-translate matrix builder. Each request word carries one
// transform (location, yaw/pitch/roll in Q2.13 radians, per-axis scale in
// Q16.16) and yields four response words, rows 0 to 3 of (R*S)*L in Q16.16,
// with last_row set on row 3. Sine and cosine come from three parallel
// CORDIC pipelines of TRIG_ITERATIONS stages (capped at 24). Rows follow
// one per cycle while rsp_stall is low. The row serialiser at the end
// sets the sustained rate: it takes a new transform only when it is idle
// or its last row is accepted, and the pipeline holds while a finished
// matrix waits on it. A response stall thus freezes the whole pipeline
// only once a finished matrix waits behind the serialiser; until then
// the pipeline keeps advancing. No word is dropped or repeated.
module model_transform_matrix_top #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtm_pkg::rsp_type rsp_data
);

   logic                               en;
   logic                               trig_valid;
   mtm_pkg::trig_type                  trig;
   mtm_pkg::side_type                  trig_side;
   logic                               rot_valid;
   logic signed [mtm_pkg::CORDIC_W-1:0] rot [0:2][0:2];
   mtm_pkg::side_type                  rot_side;
   logic                               mat_valid;
   logic signed [31:0]                 mat [0:2][0:2];
   mtm_pkg::side_type                  mat_side;
   logic                               take;

   // Advance the pipeline unless a finished matrix waits on the serialiser.
   assign en        = !mat_valid || take;
   assign req_stall = !en;

   mtm_cordic #(
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (trig_valid),
      .out_trig  (trig),
      .out_side  (trig_side)
   );

   // Rotation entries from the three sine/cosine pairs.
   mtm_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_trig   (trig),
      .in_side   (trig_side),
      .out_valid (rot_valid),
      .out_rot   (rot),
      .out_side  (rot_side)
   );

   // Column scaling with rounding and saturation.
   mtm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in_rot    (rot),
      .in_side   (rot_side),
      .out_valid (mat_valid),
      .out_elem  (mat),
      .out_side  (mat_side)
   );

   // Hold one matrix and emit it row by row.
   mtm_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_elem   (mat),
      .in_side   (mat_side),
      .in_take   (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/mtm_checker.sv
`include "model_transform_matrix_top_defines.svh"

module mtm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mtm_pkg::rsp_type rsp_data
);

   `MTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `MTM_ASSERT_NEXT(a_row_seq, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_row, rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1)
   `MTM_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_data.last_row == (rsp_data.row_index == mtm_pkg::LAST_ROW))
   `MTM_ASSERT_NOW(a_w_col, clock, reset, rsp_valid, rsp_data.elem_3 == (rsp_data.last_row ? mtm_pkg::ONE_Q16 : 32'sd0))

endmodule

bind model_transform_matrix_top mtm_checker u_mtm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/tb_model_transform_matrix_top.sv
`timescale 1ns / 1ps

module tb_model_transform_matrix_top;

   localparam int TRIG_ITER = 16;
   localparam int LATENCY   = TRIG_ITER + 12;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mtm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mtm_pkg::rsp_type rsp_data;

   // percentage of cycles each side idles, and the long hold-off request
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_cycles = 0;

   mtm_pkg::rsp_type row_queue[$];
   int               fail_count = 0;

   model_transform_matrix_top #(.TRIG_ITERATIONS(TRIG_ITER)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // floor shift of a 64 bit signed value
   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   // Q.30 product, round half up
   function automatic longint q30_mul(input longint a, input longint b);
      return shr_floor(a * b + 64'sd536870912, 30);
   endfunction

   function automatic longint atan_step(input int i);
      longint tbl[24] = '{843314856, 497837829, 263043836, 133525158,
         67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
         524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
         1023, 511, 255, 127};
      return tbl[i];
   endfunction

   // rotation-mode CORDIC at Q.30, with quadrant folding beyond pi/2
   task automatic sin_cos(input logic signed [15:0] ang, output longint s,
                          output longint c);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(ang) * 131072;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < TRIG_ITER && i < 24; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endtask

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // build the four expected rows of one transform and queue them
   task automatic predict_rows(input mtm_pkg::req_type t);
      longint           sy, cy, sp, cp, sr, cr, a, b;
      longint           rot[3][3];
      longint           sc[3];
      mtm_pkg::rsp_type row;
      sin_cos(t.yaw_angle, sy, cy);
      sin_cos(t.pitch_angle, sp, cp);
      sin_cos(t.roll_angle, sr, cr);
      a = q30_mul(sr, sp);
      b = q30_mul(cr, sp);
      rot[0][0] = q30_mul(cr, cy) - q30_mul(a, sy);
      rot[0][1] = q30_mul(sr, cy) + q30_mul(b, sy);
      rot[0][2] = -q30_mul(cp, sy);
      rot[1][0] = -q30_mul(sr, cp);
      rot[1][1] = q30_mul(cr, cp);
      rot[1][2] = sp;
      rot[2][0] = q30_mul(cr, sy) + q30_mul(a, cy);
      rot[2][1] = q30_mul(sr, sy) - q30_mul(b, cy);
      rot[2][2] = q30_mul(cp, cy);
      sc[0] = t.scale_x;
      sc[1] = t.scale_y;
      sc[2] = t.scale_z;
      for (int r = 0; r < 3; r++) begin
         row.row_index = r[1:0];
         row.elem_0 = clamp32(q30_mul(rot[r][0], sc[0]));
         row.elem_1 = clamp32(q30_mul(rot[r][1], sc[1]));
         row.elem_2 = clamp32(q30_mul(rot[r][2], sc[2]));
         row.elem_3 = '0;
         row.last_row = 1'b0;
         row_queue.push_back(row);
      end
      row.row_index = mtm_pkg::LAST_ROW;
      row.elem_0 = t.loc_x;
      row.elem_1 = t.loc_y;
      row.elem_2 = t.loc_z;
      row.elem_3 = mtm_pkg::ONE_Q16;
      row.last_row = 1'b1;
      row_queue.push_back(row);
   endtask

   // offer one transform word, idle first at random, hold until taken
   task automatic send_transform(input mtm_pkg::req_type t);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      predict_rows(t);
   endtask

   // drive the response stall: random, or a long counted hold-off
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each accepted row word with the oldest expectation
   always @(posedge clock) begin
      mtm_pkg::rsp_type exp_row;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (row_queue.size() == 0) begin
            $display("%0t unexpected row word: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            exp_row = row_queue.pop_front();
            if (rsp_data !== exp_row) begin
               $display("%0t row mismatch: expected %h actual %h",
                        $time, exp_row, rsp_data);
               fail_count++;
            end
         end
      end
   end

   function automatic logic signed [15:0] rand_angle();
      return 16'($signed($urandom_range(51472)) - 25736);
   endfunction

   function automatic mtm_pkg::req_type rand_transform(input bit wide);
      mtm_pkg::req_type t;
      t.loc_x = $urandom;
      t.loc_y = $urandom;
      t.loc_z = $urandom;
      // mostly in-range angles; sometimes any 16 bit pattern
      t.yaw_angle   = ($urandom_range(9) == 0) ? 16'($urandom) : rand_angle();
      t.pitch_angle = ($urandom_range(9) == 0) ? 16'($urandom) : rand_angle();
      t.roll_angle  = ($urandom_range(9) == 0) ? 16'($urandom) : rand_angle();
      if (wide) begin
         t.scale_x = $urandom; t.scale_y = $urandom; t.scale_z = $urandom;
      end else begin
         t.scale_x = $signed($urandom_range(1 << 20)) - (1 << 19);
         t.scale_y = $signed($urandom_range(1 << 20)) - (1 << 19);
         t.scale_z = $signed($urandom_range(1 << 20)) - (1 << 19);
      end
      return t;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      wait (row_queue.size() == 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   // extremes of the angle, scale and x/y location fields, folded angles and saturating scales
   task automatic test_directed();
      mtm_pkg::req_type t;
      logic signed [15:0] angs[8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
         -16'sd12868, 16'sh7FFF, 16'sh8000, 16'sd12869};
      for (int i = 0; i < 8; i++) begin
         t.loc_x = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         t.loc_y = (i % 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
         t.loc_z = i * 32'h0001_0000;
         t.yaw_angle   = angs[i];
         t.pitch_angle = angs[(i + 3) % 8];
         t.roll_angle  = angs[(i + 5) % 8];
         t.scale_x = (i < 4) ? 32'h0001_0000 : 32'h7FFF_FFFF;
         t.scale_y = (i < 4) ? 32'hFFFF_0000 : 32'h8000_0000;
         t.scale_z = (i % 3 == 0) ? 32'h0 : 32'h7FFF_FFFF;
         send_transform(t);
      end
      drain();
   endtask

   task automatic test_random(input int n, input int unsigned sidle,
                              input int unsigned rstall);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < n; i++)
         send_transform(rand_transform($urandom_range(3) == 0));
      drain();
   endtask

   // hold off the receiver long enough that the pipeline backs up
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 200;
      for (int i = 0; i < 30; i++)
         send_transform(rand_transform(1'b1));
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100, 0, 0);
      test_random(100, 60, 0);
      test_random(100, 0, 60);
      test_random(100, 34, 34);
      test_backpressure();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
